// ===== design/gcode_word_point_parser_macros.svh =====
// Assertion macros for the G-code point parser checker.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef GCODE_WORD_POINT_PARSER_MACROS_SVH
`define GCODE_WORD_POINT_PARSER_MACROS_SVH

// Same-cycle implication.
`define GWPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GWPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gwpp_pkg.sv =====
// Shared constants for the G-code point parser: character codes, G codes,
// channel commands and the decimal place-weight table. No dependencies.
`default_nettype none

package gwpp_pkg;

  localparam int unsigned FRACTION_DIGITS_DEFAULT = 3;
  localparam int unsigned COORD_WIDTH_DEFAULT     = 32;

  // Input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_GRAPHIC_LO = 8'h21;
  localparam logic [7:0] CHAR_GRAPHIC_HI = 8'h7E;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CHAR_CASE_GAP   = 8'h20;
  localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
  localparam logic [7:0] CHAR_PLUS       = 8'h2B;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_POINT      = 8'h2E;
  localparam logic [7:0] CHAR_SEMI       = 8'h3B;
  localparam logic [7:0] CHAR_X          = 8'h58;
  localparam logic [7:0] CHAR_Y          = 8'h59;
  localparam logic [7:0] CHAR_G          = 8'h47;
  localparam logic [7:0] CHAR_NONE       = 8'h00;

  // G codes
  localparam logic [7:0] G_MOTION_MAX   = 8'd3;
  localparam logic [7:0] G_ABSOLUTE     = 8'd90;
  localparam logic [7:0] G_INCREMENTAL  = 8'd91;
  localparam logic [7:0] G_SET_POSITION = 8'd92;
  localparam logic [7:0] G_SAT_LIMIT    = 8'd25;
  localparam logic [3:0] G_SAT_DIGIT    = 4'd5;
  localparam logic [7:0] G_SAT_VALUE    = 8'd255;

  // Decimal place weights 10^0 .. 10^7
  localparam logic [23:0] POW10 [8] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000,
    24'd1000000, 24'd10000000
  };

endpackage

`default_nettype wire

// ===== design/gcode_word_point_parser.sv =====
// G-code word parser: turns a character stream into one point per line.
//
// Input channel: valid/ready, fields command_i and character_i. command_i low
// carries a program character; command_i high ends the line and the character
// is ignored. Characters outside 0x21..0x7E are skipped, ';' opens a comment.
// Output channel: valid/ready, one transfer per end of line carrying X, Y,
// the modal motion type and the start-of-path flag.
// Throughput: one input item per cycle unless stalled. All parsing for an item
// is done in the cycle it is accepted; the result of an end-of-line item appears
// in the output register on the following cycle.
// Stall: while a result waits in the output register and out_ready_i is low,
// in_ready_o is low and the whole parser holds. A result taken in the same
// cycle frees the register, so back-to-back lines still run at full rate.
// Reset (rst_ni low, asynchronous): point at 0,0, motion G0, absolute mode,
// start flag set for the first line, no result pending.
// Depends on gwpp_pkg and gwpp_coord_apply.
`default_nettype none

module gcode_word_point_parser
  import gwpp_pkg::*;
#(
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEFAULT,
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          command_i,
  input  wire logic        [7:0]             character_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      signed [COORD_WIDTH-1:0] x_position_o,
  output logic      signed [COORD_WIDTH-1:0] y_position_o,
  output logic             [1:0]             motion_type_o,
  output logic                               start_flag_o
);

  localparam int unsigned FcW = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
  localparam int unsigned WW  = (COORD_WIDTH + 4 > 29) ? COORD_WIDTH + 4 : 29;
  localparam logic [WW-1:0]  MagLimitW = WW'({1'b1, {(COORD_WIDTH-1){1'b0}}});
  localparam logic [2:0]     FdIdx     = 3'(FRACTION_DIGITS);
  localparam logic [FcW-1:0] FdCount   = FcW'(FRACTION_DIGITS);

  // Parser state
  logic signed [COORD_WIDTH-1:0] point_x_q, point_x_d;
  logic signed [COORD_WIDTH-1:0] point_y_q, point_y_d;
  logic [1:0]             motion_q, motion_d;
  logic                   incr_q, incr_d;
  logic                   setpos_q, setpos_d;
  logic                   start_q, start_d;
  logic                   comment_q, comment_d;
  logic [7:0]             letter_q, letter_d;
  logic                   neg_q, neg_d;
  logic [COORD_WIDTH-1:0] mag_q, mag_d;
  logic [FcW-1:0]         frac_q, frac_d;
  logic                   point_seen_q, point_seen_d;
  logic                   chars_seen_q, chars_seen_d;
  logic                   stopped_q, stopped_d;
  logic [7:0]             g_q, g_d;

  // Result register
  logic                          out_valid_q;
  logic signed [COORD_WIDTH-1:0] x_out_q, y_out_q;
  logic [1:0]                    motion_out_q;
  logic                          start_out_q;

  logic       accept, is_eol, graphic, is_upper, is_lower, is_letter, is_semi;
  logic       is_digit, is_sign, live_char, closes_word, num_char;
  logic [7:0] letter_up;
  logic [3:0] digit;
  logic [2:0] weight_idx;
  logic [27:0] digit_weight;
  logic [WW-1:0] mag_scaled, mag_sum;
  logic [COORD_WIDTH-1:0] mag_next;
  logic [7:0] g_next;
  logic       g_en, setpos_now, start_now;
  logic signed [COORD_WIDTH-1:0] apply_base, apply_value;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Character classes
  always_comb begin
    is_eol    = (command_i == CMD_EOL);
    graphic   = (character_i >= CHAR_GRAPHIC_LO) && (character_i <= CHAR_GRAPHIC_HI);
    is_upper  = (character_i >= CHAR_UPPER_A) && (character_i <= CHAR_UPPER_Z);
    is_lower  = (character_i >= CHAR_LOWER_A) && (character_i <= CHAR_LOWER_Z);
    is_letter = is_upper || is_lower;
    is_semi   = (character_i == CHAR_SEMI);
    is_digit  = (character_i >= CHAR_DIGIT_0) && (character_i <= CHAR_DIGIT_9);
    is_sign   = (character_i == CHAR_PLUS) || (character_i == CHAR_MINUS);
    letter_up = is_lower ? (character_i - CHAR_CASE_GAP) : character_i;
    digit     = character_i[3:0];
    live_char = accept && !is_eol && !comment_q && graphic;
    // Letter, ';' or end of line (outside a comment) finishes the pending word
    closes_word = accept && !comment_q && (is_eol || (graphic && (is_letter || is_semi)));
    num_char    = live_char && !is_letter && !is_semi && (letter_q != CHAR_NONE)
                  && !stopped_q;
  end

  // Scaled magnitude: kept as magnitude * 10^(digits still missing), saturated
  always_comb begin
    weight_idx   = point_seen_q ? (FdIdx - 3'd1 - 3'(frac_q)) : FdIdx;
    digit_weight = 28'(digit) * 28'(POW10[weight_idx]);
    mag_scaled   = point_seen_q ? WW'(mag_q) : (WW'(mag_q) << 3) + (WW'(mag_q) << 1);
    mag_sum      = mag_scaled + WW'(digit_weight);
    mag_next     = (mag_sum > MagLimitW) ? MagLimitW[COORD_WIDTH-1:0]
                                         : mag_sum[COORD_WIDTH-1:0];
    if ((g_q > G_SAT_LIMIT) || ((g_q == G_SAT_LIMIT) && (digit > G_SAT_DIGIT))) begin
      g_next = G_SAT_VALUE;
    end else begin
      g_next = 8'(11'(g_q) * 11'd10 + 11'(digit));
    end
  end

  assign apply_base = (letter_q == CHAR_Y) ? point_y_q : point_x_q;

  gwpp_coord_apply #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_coord_apply (
    .base_i      (apply_base),
    .absolute_i  (!incr_q || setpos_q),
    .negative_i  (neg_q),
    .magnitude_i (mag_q),
    .value_o     (apply_value)
  );

  // Word application and modal state
  always_comb begin
    point_x_d = point_x_q;
    point_y_d = point_y_q;
    motion_d  = motion_q;
    incr_d    = incr_q;
    g_en      = closes_word && (letter_q == CHAR_G) && !(neg_q && (g_q != 8'd0));
    if (closes_word && (letter_q == CHAR_X)) begin
      point_x_d = apply_value;
    end
    if (closes_word && (letter_q == CHAR_Y)) begin
      point_y_d = apply_value;
    end
    if (g_en && (g_q <= G_MOTION_MAX)) begin
      motion_d = g_q[1:0];
    end
    if (g_en && (g_q == G_ABSOLUTE)) begin
      incr_d = 1'b0;
    end
    if (g_en && (g_q == G_INCREMENTAL)) begin
      incr_d = 1'b1;
    end
    setpos_now = setpos_q || (g_en && (g_q == G_SET_POSITION));
    start_now  = start_q || (g_en && (g_q == G_SET_POSITION));
    // Per-line flags drop after end of line
    setpos_d  = (accept && is_eol) ? 1'b0 : setpos_now;
    start_d   = (accept && is_eol) ? 1'b0 : start_now;
    comment_d = comment_q;
    if (accept && is_eol) begin
      comment_d = 1'b0;
    end else if (live_char && is_semi) begin
      comment_d = 1'b1;
    end
  end

  // Word accumulation
  always_comb begin
    letter_d     = letter_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    frac_d       = frac_q;
    point_seen_d = point_seen_q;
    chars_seen_d = chars_seen_q;
    stopped_d    = stopped_q;
    g_d          = g_q;
    if (accept && (is_eol || (live_char && (is_letter || is_semi)))) begin
      letter_d     = (!is_eol && is_letter) ? letter_up : CHAR_NONE;
      neg_d        = 1'b0;
      mag_d        = '0;
      frac_d       = '0;
      point_seen_d = 1'b0;
      chars_seen_d = 1'b0;
      stopped_d    = 1'b0;
      g_d          = 8'd0;
    end else if (num_char) begin
      if (is_sign && !chars_seen_q) begin
        neg_d        = (character_i == CHAR_MINUS);
        chars_seen_d = 1'b1;
      end else if (is_digit) begin
        chars_seen_d = 1'b1;
        if (!point_seen_q) begin
          mag_d = mag_next;
          g_d   = g_next;
        end else if (frac_q < FdCount) begin
          mag_d  = mag_next;
          frac_d = frac_q + FcW'(1);
        end
      end else if ((character_i == CHAR_POINT) && !point_seen_q) begin
        point_seen_d = 1'b1;
        chars_seen_d = 1'b1;
      end else begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q    <= '0;
      point_y_q    <= '0;
      motion_q     <= 2'd0;
      incr_q       <= 1'b0;
      setpos_q     <= 1'b0;
      start_q      <= 1'b1;
      comment_q    <= 1'b0;
      letter_q     <= CHAR_NONE;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      frac_q       <= '0;
      point_seen_q <= 1'b0;
      chars_seen_q <= 1'b0;
      stopped_q    <= 1'b0;
      g_q          <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      point_x_q    <= point_x_d;
      point_y_q    <= point_y_d;
      motion_q     <= motion_d;
      incr_q       <= incr_d;
      setpos_q     <= setpos_d;
      start_q      <= start_d;
      comment_q    <= comment_d;
      letter_q     <= letter_d;
      neg_q        <= neg_d;
      mag_q        <= mag_d;
      frac_q       <= frac_d;
      point_seen_q <= point_seen_d;
      chars_seen_q <= chars_seen_d;
      stopped_q    <= stopped_d;
      g_q          <= g_d;
      if (accept && is_eol) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on end of line, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept && is_eol) begin
      x_out_q      <= point_x_d;
      y_out_q      <= point_y_d;
      motion_out_q <= motion_d;
      start_out_q  <= start_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_position_o  = x_out_q;
  assign y_position_o  = y_out_q;
  assign motion_type_o = motion_out_q;
  assign start_flag_o  = start_out_q;

endmodule

`default_nettype wire

// ===== design/gwpp_coord_apply.sv =====
// Saturating coordinate update for one X or Y word.
// Adds or sets a signed word value given as sign and scaled magnitude.
`default_nettype none

module gwpp_coord_apply
  import gwpp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  wire logic signed [COORD_WIDTH-1:0] base_i,
  input  wire logic                          absolute_i,
  input  wire logic                          negative_i,
  input  wire logic        [COORD_WIDTH-1:0] magnitude_i,
  output logic      signed [COORD_WIDTH-1:0] value_o
);

  localparam logic [COORD_WIDTH-1:0] MagLimit = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [COORD_WIDTH-1:0] mag_eff;
  logic [COORD_WIDTH:0]   base_ext;
  logic [COORD_WIDTH:0]   sum;

  always_comb begin
    // A positive value at the magnitude limit clips to the largest coordinate
    mag_eff  = (!negative_i && (magnitude_i == MagLimit)) ? CoordMax : magnitude_i;
    base_ext = absolute_i ? '0 : {base_i[COORD_WIDTH-1], base_i};
    if (negative_i) begin
      sum = base_ext - {1'b0, mag_eff};
    end else begin
      sum = base_ext + {1'b0, mag_eff};
    end
    if (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]) begin
      value_o = sum[COORD_WIDTH] ? CoordMin : CoordMax;
    end else begin
      value_o = sum[COORD_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/gwpp_checker.sv =====
// Port-level checker for gcode_word_point_parser, bound to the top level.
// Depends on gwpp_pkg and gcode_word_point_parser_macros.svh.
`default_nettype none
`include "gcode_word_point_parser_macros.svh"

module gwpp_checker
  import gwpp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          command_i,
  input wire logic        [7:0]             character_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [COORD_WIDTH-1:0] x_position_o,
  input wire logic signed [COORD_WIDTH-1:0] y_position_o,
  input wire logic        [1:0]             motion_type_o,
  input wire logic                          start_flag_o
);

  logic in_xfer, out_free;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;

  `GWPP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `GWPP_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(x_position_o) && $stable(y_position_o) && $stable(motion_type_o) && $stable(start_flag_o), "stalled result changed")
  `GWPP_ASSERT_NEXT(a_eol_result, in_xfer && (command_i == CMD_EOL), out_valid_o, "end of line gave no result")
  `GWPP_ASSERT_NEXT(a_char_no_result, in_xfer && (command_i == CMD_CHAR) && out_free, !out_valid_o, "character transfer gave a result")
  `GWPP_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

endmodule

bind gcode_word_point_parser gwpp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_gwpp_checker (.*);

`default_nettype wire

// ===== test/tb_gcode_word_point_parser.sv =====
// Testbench for gcode_word_point_parser: directed lines, then random G-code lines and noise.
// Each end-of-line result is checked against the in-bench model or a preset point.
// Depends on gwpp_pkg and the parser RTL.
`default_nettype none

module tb_gcode_word_point_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gwpp_pkg::*;

  localparam int COORD_W     = COORD_WIDTH_DEFAULT;
  localparam int FRAC_DIGITS = FRACTION_DIGITS_DEFAULT;
  localparam longint unsigned MAG_LIMIT = 64'd1 << (COORD_W - 1);
  localparam longint COORD_MAX = longint'(MAG_LIMIT - 64'd1);
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam int DIR_N = 18;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [1:0]                motion;
    logic                      start;
  } point_t;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
    bit         drain;
    bit         typed;
    point_t     want;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic command_i = CMD_CHAR;
  logic [7:0] character_i = CHAR_NONE;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [COORD_W-1:0] x_position_o;
  logic signed [COORD_W-1:0] y_position_o;
  logic [1:0] motion_type_o;
  logic start_flag_o;

  gcode_word_point_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .character_i   (character_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_position_o  (x_position_o),
    .y_position_o  (y_position_o),
    .motion_type_o (motion_type_o),
    .start_flag_o  (start_flag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Line parser model state
  longint          pos_x;
  longint          pos_y;
  logic [1:0]      mode_motion;
  bit              mode_incr;
  bit              line_set_pos;
  bit              line_start;
  logic [7:0]      word_ltr;
  bit              num_neg;
  longint unsigned num_mag;
  int unsigned     num_frac;
  bit              num_point;
  bit              num_any;
  bit              num_stop;
  int unsigned     g_code;
  bit              line_comment;

  stim_t  stimulus_q[$];
  point_t pending_points[$];
  bit     cur_typed;
  point_t cur_want;
  point_t model_pt;
  point_t want_pt;
  point_t got_pt;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;

  function automatic void clear_word();
    word_ltr  = CHAR_NONE;
    num_neg   = 1'b0;
    num_mag   = 0;
    num_frac  = 0;
    num_point = 1'b0;
    num_any   = 1'b0;
    num_stop  = 1'b0;
    g_code    = 0;
  endfunction

  function automatic void model_reset();
    pos_x        = 0;
    pos_y        = 0;
    mode_motion  = 2'd0;
    mode_incr    = 1'b0;
    line_set_pos = 1'b0;
    line_start   = 1'b1;
    line_comment = 1'b0;
    clear_word();
  endfunction

  function automatic longint unsigned mag_shift_in(longint unsigned m, int unsigned d);
    if (m > (MAG_LIMIT - d) / 10) return MAG_LIMIT;
    return m * 10 + d;
  endfunction

  function automatic longint word_value();
    longint unsigned m;
    m = num_mag;
    for (int unsigned i = num_frac; i < FRAC_DIGITS; i++) m = mag_shift_in(m, 0);
    if (num_neg) return (m >= MAG_LIMIT) ? COORD_MIN : -longint'(m);
    return (m > MAG_LIMIT - 1) ? COORD_MAX : longint'(m);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > COORD_MAX - b) return COORD_MAX;
    if (b < 0 && a < COORD_MIN - b) return COORD_MIN;
    return a + b;
  endfunction

  function automatic void apply_word();
    bit absolute;
    longint v;
    absolute = !mode_incr || line_set_pos;
    if (word_ltr == CHAR_X) begin
      v = word_value();
      pos_x = absolute ? v : sat_add(pos_x, v);
    end else if (word_ltr == CHAR_Y) begin
      v = word_value();
      pos_y = absolute ? v : sat_add(pos_y, v);
    end else if (word_ltr == CHAR_G && !(num_neg && g_code != 0)) begin
      if (g_code <= G_MOTION_MAX) begin
        mode_motion = 2'(g_code);
      end else if (g_code == G_SET_POSITION) begin
        line_set_pos = 1'b1;
        line_start   = 1'b1;
      end else if (g_code == G_ABSOLUTE) begin
        mode_incr = 1'b0;
      end else if (g_code == G_INCREMENTAL) begin
        mode_incr = 1'b1;
      end
    end
  endfunction

  function automatic void number_char(logic [7:0] c);
    int unsigned d;
    if (num_stop) return;
    if ((c == CHAR_PLUS || c == CHAR_MINUS) && !num_any) begin
      num_neg = (c == CHAR_MINUS);
      num_any = 1'b1;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = 32'(c - CHAR_DIGIT_0);
      num_any = 1'b1;
      if (!num_point) begin
        num_mag = mag_shift_in(num_mag, d);
        g_code = (g_code > G_SAT_LIMIT || (g_code == G_SAT_LIMIT && d > G_SAT_DIGIT)) ?
                 G_SAT_VALUE : g_code * 10 + d;
      end else if (num_frac < FRAC_DIGITS) begin
        num_mag = mag_shift_in(num_mag, d);
        num_frac++;
      end
    end else if (c == CHAR_POINT && !num_point) begin
      num_point = 1'b1;
      num_any   = 1'b1;
    end else begin
      num_stop = 1'b1;
    end
  endfunction

  // Advance the model by one transfer; return 1 when it emits a point.
  function automatic bit parse_item(logic cmd, logic [7:0] c, output point_t pt);
    pt = '0;
    if (cmd == CMD_EOL) begin
      if (!line_comment) apply_word();
      pt.x = pos_x[COORD_W-1:0];
      pt.y = pos_y[COORD_W-1:0];
      pt.motion = mode_motion;
      pt.start = line_start;
      line_set_pos = 1'b0;
      line_start   = 1'b0;
      line_comment = 1'b0;
      clear_word();
      return 1'b1;
    end
    if (line_comment || c < CHAR_GRAPHIC_LO || c > CHAR_GRAPHIC_HI) return 1'b0;
    if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
        (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
      apply_word();
      clear_word();
      word_ltr = (c >= CHAR_LOWER_A) ? c - CHAR_CASE_GAP : c;
    end else if (c == CHAR_SEMI) begin
      apply_word();
      clear_word();
      line_comment = 1'b1;
    end else if (word_ltr != CHAR_NONE) begin
      number_char(c);
    end
    return 1'b0;
  endfunction

  task automatic add_item(logic cmd, logic [7:0] ch, bit typed, point_t want);
    stim_t s;
    s.cmd   = cmd;
    s.ch    = ch;
    s.drain = 1'b0;
    s.typed = typed;
    s.want  = want;
    stimulus_q = {stimulus_q, s};
  endtask

  task automatic add_char(logic [7:0] ch);
    add_item(CMD_CHAR, ch, 1'b0, '0);
  endtask

  task automatic add_text(string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k]);
  endtask

  task automatic add_drain();
    stim_t s;
    s = '{cmd: CMD_CHAR, ch: CHAR_NONE, drain: 1'b1, typed: 1'b0, want: '0};
    stimulus_q = {stimulus_q, s};
  endtask

  task automatic add_number();
    int unsigned n_int;
    case ($urandom_range(0, 5))
      0: add_char(CHAR_MINUS);
      1: add_char(CHAR_PLUS);
      default: ;
    endcase
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
    repeat (n_int) add_char(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 1) begin
      add_char(CHAR_POINT);
      repeat ($urandom_range(0, 5)) add_char(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
    end
    // break the number now and then
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0: add_char(CHAR_MINUS);
        1: add_char(CHAR_POINT);
        default: add_char(CHAR_PLUS);
      endcase
      add_char(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_random_line();
    int unsigned pick;
    bit is_g;
    logic [7:0] ltr;
    string others;
    int g_list [7];
    others = "NZRFMS";
    g_list = '{0, 1, 2, 3, 90, 91, 92};
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 9);
      is_g = 1'b0;
      if (pick < 3) begin
        ltr = CHAR_X;
      end else if (pick < 6) begin
        ltr = CHAR_Y;
      end else if (pick < 9) begin
        ltr = CHAR_G;
        is_g = 1'b1;
      end else begin
        ltr = others[$urandom_range(0, others.len() - 1)];
      end
      if ($urandom_range(0, 3) == 0) ltr = ltr + CHAR_CASE_GAP;
      add_char(ltr);
      if (is_g && $urandom_range(0, 4) != 0)
        add_text($sformatf("%0d", g_list[$urandom_range(0, 6)]));
      else add_number();
      if ($urandom_range(0, 1) == 1) add_char(CHAR_SPACE);
      if ($urandom_range(0, 19) == 0) add_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 14) == 0) begin
      add_char(CHAR_SEMI);
      repeat ($urandom_range(0, 6))
        add_char(8'($urandom_range(CHAR_GRAPHIC_LO, CHAR_GRAPHIC_HI)));
    end
    add_item(CMD_EOL, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic add_noise_line();
    repeat ($urandom_range(1, 16)) begin
      if ($urandom_range(0, 7) == 0) add_item(CMD_EOL, 8'($urandom_range(0, 255)), 1'b0, '0);
      else add_char(8'($urandom_range(0, 255)));
    end
    add_item(CMD_EOL, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Check results and advance the model on every input transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_pt = '{x_position_o, y_position_o, motion_type_o, start_flag_o};
        if (pending_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected point: x=%0d y=%0d g%0d start=%0d",
                     got_pt.x, got_pt.y, got_pt.motion, got_pt.start);
        end else begin
          want_pt = pending_points.pop_front();
          if (got_pt.x !== want_pt.x || got_pt.y !== want_pt.y ||
              got_pt.motion !== want_pt.motion || got_pt.start !== want_pt.start) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"point mismatch: want x=%0d y=%0d g%0d start=%0d, ",
                        "got x=%0d y=%0d g%0d start=%0d"},
                       want_pt.x, want_pt.y, want_pt.motion, want_pt.start,
                       got_pt.x, got_pt.y, got_pt.motion, got_pt.start);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        accepted_count++;
        if (parse_item(command_i, character_i, model_pt)) begin
          if (cur_typed) model_pt = cur_want;
          pending_points = {pending_points, model_pt};
        end
      end
    end
  end

  // Receiver: changing ready patterns, plus two long hold-offs
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned mode_left;
    int unsigned rx_mode;
    hold_left  = 0;
    holds_done = 0;
    mode_left  = 0;
    rx_mode    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && accepted_count >= ((holds_done == 0) ? 600 : 1500)) begin
        out_ready_i <= 1'b0;
        hold_left = 400;
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    string  dir_text [DIR_N];
    bit     dir_typed [DIR_N];
    point_t dir_want [DIR_N];
    int     burst_left;
    int     gap;
    int     dir_count;
    int     waited;

    model_reset();
    dir_text = '{
      "",
      "G1 X1.5 Y-2.25",
      "X99999999999",
      "x-99999999999",
      "G91 X+1.0005 y.5",
      "G92 X0 Y0",
      "X2147483.647 X2147483.647",
      "Y-2147483.648 Y-1",
      "G90 g3 x1;X5 Y7",
      "G-2 G02.9 G256 G4 G93 G-0",
      "12 N5 Z3 R1 X1-2 Y.1.2",
      "X+-3 G",
      "X\t1\2003 \377Y 4",
      "G91 G92 X5",
      "G90 X1.23456 Y-0",
      ";G1 X9",
      "G1 X-2147483.648",
      "X2147483.6475"
    };
    foreach (dir_want[r]) begin
      dir_want[r] = '0;
      dir_typed[r] = 1'b0;
    end
    // after reset, simple values, saturation, set position
    dir_typed[0] = 1'b1;
    dir_want[0]  = '{0, 0, 2'd0, 1'b1};
    dir_typed[1] = 1'b1;
    dir_want[1]  = '{1500, -2250, 2'd1, 1'b0};
    dir_typed[2] = 1'b1;
    dir_want[2]  = '{COORD_W'(COORD_MAX), -2250, 2'd1, 1'b0};
    dir_typed[3] = 1'b1;
    dir_want[3]  = '{COORD_W'(COORD_MIN), -2250, 2'd1, 1'b0};
    dir_typed[5] = 1'b1;
    dir_want[5]  = '{0, 0, 2'd1, 1'b1};

    for (int r = 0; r < DIR_N; r++) begin
      add_text(dir_text[r]);
      add_item(CMD_EOL, CHAR_NONE, dir_typed[r], dir_want[r]);
    end
    add_drain();
    dir_count = stimulus_q.size();
    while (stimulus_q.size() < dir_count + RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) add_noise_line();
      else add_random_line();
      if ($urandom_range(0, 29) == 0) add_drain();
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    burst_left = 0;
    foreach (stimulus_q[i]) begin
      if (stimulus_q[i].drain) begin
        // hold the input until every pending point is out
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending_points.size() != 0);
        burst_left = 0;
      end else begin
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        in_valid_i  <= 1'b1;
        command_i   <= stimulus_q[i].cmd;
        character_i <= stimulus_q[i].ch;
        cur_typed = stimulus_q[i].typed;
        cur_want  = stimulus_q[i].want;
        do @(posedge clk_i); while (!in_ready_o);
        @(negedge clk_i);
        burst_left--;
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_points.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    fail_count += pending_points.size();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/gwpp_pkg.sv
design/gwpp_coord_apply.sv
design/gcode_word_point_parser.sv
design/gwpp_checker.sv
test/tb_gcode_word_point_parser.sv
